[hdl/lcm_pkg.sv]
// Package for the least common multiple block: payload types, microcode and its codes.
`timescale 1ns / 1ps
`default_nettype none

package lcm_pkg;

    // Fixed field widths of the request and result payloads.
    localparam int FIELD_W = 16;
    localparam int MULT_W  = 48;

    // Default operand width handed to the top level.
    localparam int DEF_OPERAND_WIDTH = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] first_value;
        logic [FIELD_W-1:0] second_value;
        logic [FIELD_W-1:0] third_value;
        logic               use_third;
    } lcm_req_t;

    typedef struct packed {
        logic [MULT_W-1:0] multiple;
        logic              status;
    } lcm_res_t;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ZERO = 1'b1;

    // Datapath operation codes.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD1  = 4'd1;
    localparam logic [OP_W-1:0] OP_GCD    = 4'd2;
    localparam logic [OP_W-1:0] OP_GFIX   = 4'd3;
    localparam logic [OP_W-1:0] OP_DINIT1 = 4'd4;
    localparam logic [OP_W-1:0] OP_DSTEP  = 4'd5;
    localparam logic [OP_W-1:0] OP_MINIT1 = 4'd6;
    localparam logic [OP_W-1:0] OP_MSTEP  = 4'd7;
    localparam logic [OP_W-1:0] OP_LOAD2  = 4'd8;
    localparam logic [OP_W-1:0] OP_DINIT2 = 4'd9;
    localparam logic [OP_W-1:0] OP_MINIT2 = 4'd10;
    localparam logic [OP_W-1:0] OP_DONE   = 4'd11;
    localparam logic [OP_W-1:0] OP_ERR    = 4'd12;

    // Jump condition codes.
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NONE = 3'd0;
    localparam logic [COND_W-1:0] C_ERR  = 3'd1;
    localparam logic [COND_W-1:0] C_BNZ  = 3'd2;
    localparam logic [COND_W-1:0] C_CNT  = 3'd3;
    localparam logic [COND_W-1:0] C_TWO  = 3'd4;

    // Program addresses.
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] STEP_LOAD1  = 5'd0;
    localparam logic [PC_W-1:0] STEP_GCD1   = 5'd1;
    localparam logic [PC_W-1:0] STEP_GFIX1  = 5'd2;
    localparam logic [PC_W-1:0] STEP_DINIT1 = 5'd3;
    localparam logic [PC_W-1:0] STEP_DIV1   = 5'd4;
    localparam logic [PC_W-1:0] STEP_MINIT1 = 5'd5;
    localparam logic [PC_W-1:0] STEP_MUL1   = 5'd6;
    localparam logic [PC_W-1:0] STEP_BRANCH = 5'd7;
    localparam logic [PC_W-1:0] STEP_LOAD2  = 5'd8;
    localparam logic [PC_W-1:0] STEP_GCD2   = 5'd9;
    localparam logic [PC_W-1:0] STEP_GFIX2  = 5'd10;
    localparam logic [PC_W-1:0] STEP_DINIT2 = 5'd11;
    localparam logic [PC_W-1:0] STEP_DIV2   = 5'd12;
    localparam logic [PC_W-1:0] STEP_MINIT2 = 5'd13;
    localparam logic [PC_W-1:0] STEP_MUL2   = 5'd14;
    localparam logic [PC_W-1:0] STEP_DONE   = 5'd15;
    localparam logic [PC_W-1:0] STEP_ERR    = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } uop_t;

    // The control store. A step jumps to its target when its condition holds,
    // otherwise it falls through to the next address.
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t w;
        begin
            case (pc)
                STEP_LOAD1:  w = '{op: OP_LOAD1,  cond: C_ERR,  target: STEP_ERR};
                STEP_GCD1:   w = '{op: OP_GCD,    cond: C_BNZ,  target: STEP_GCD1};
                STEP_GFIX1:  w = '{op: OP_GFIX,   cond: C_NONE, target: STEP_LOAD1};
                STEP_DINIT1: w = '{op: OP_DINIT1, cond: C_NONE, target: STEP_LOAD1};
                STEP_DIV1:   w = '{op: OP_DSTEP,  cond: C_CNT,  target: STEP_DIV1};
                STEP_MINIT1: w = '{op: OP_MINIT1, cond: C_NONE, target: STEP_LOAD1};
                STEP_MUL1:   w = '{op: OP_MSTEP,  cond: C_CNT,  target: STEP_MUL1};
                STEP_BRANCH: w = '{op: OP_NONE,   cond: C_TWO,  target: STEP_DONE};
                STEP_LOAD2:  w = '{op: OP_LOAD2,  cond: C_NONE, target: STEP_LOAD1};
                STEP_GCD2:   w = '{op: OP_GCD,    cond: C_BNZ,  target: STEP_GCD2};
                STEP_GFIX2:  w = '{op: OP_GFIX,   cond: C_NONE, target: STEP_LOAD1};
                STEP_DINIT2: w = '{op: OP_DINIT2, cond: C_NONE, target: STEP_LOAD1};
                STEP_DIV2:   w = '{op: OP_DSTEP,  cond: C_CNT,  target: STEP_DIV2};
                STEP_MINIT2: w = '{op: OP_MINIT2, cond: C_NONE, target: STEP_LOAD1};
                STEP_MUL2:   w = '{op: OP_MSTEP,  cond: C_CNT,  target: STEP_MUL2};
                STEP_DONE:   w = '{op: OP_DONE,   cond: C_NONE, target: STEP_LOAD1};
                STEP_ERR:    w = '{op: OP_ERR,    cond: C_NONE, target: STEP_LOAD1};
                default:     w = '{op: OP_ERR,    cond: C_NONE, target: STEP_LOAD1};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/lcm_of_two_or_three.sv]
// Least common multiple of two or three operands, run by a microcoded sequencer.
// The run time is set by the binary GCD loops, a W-step divider and a W-step multiplier
// (W = OPERAND_WIDTH); two operands take one pass of each, three operands two passes.
// An operand of zero in use goes straight to the error step, which gives a zero multiple.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: asynchronous, active low; clears the sequencer and the output valid, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lcm_of_two_or_three
    import lcm_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lcm_req_t operands,
    input  wire logic     operands_valid,
    output logic          operands_stall,
    output lcm_res_t      result,
    output logic          result_valid,
    input  wire logic     result_stall
);

    // Working widths. The gcd pair must hold the two-operand multiple, and the
    // accumulator the full three-operand multiple.
    localparam int W  = OPERAND_WIDTH;
    localparam int GW = 2 * W;
    localparam int MW = 3 * W;
    localparam int KW = $clog2(GW);
    localparam int CW = $clog2(W);

    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    // Sequencer state.
    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;

    // Captured operands. Each is the low W bits of its field.
    logic [W-1:0] va_reg, va_next;
    logic [W-1:0] vb_reg, vb_next;
    logic [W-1:0] vc_reg, vc_next;
    logic         two_reg, two_next;
    logic         err_reg, err_next;

    // GCD pair and the count of common factors of two.
    logic [GW-1:0] a_reg, a_next;
    logic [GW-1:0] b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;

    // Restoring divider: dn holds the dividend and collects the quotient.
    logic [W-1:0] dn_reg, dn_next;
    logic [W-1:0] dd_reg, dd_next;
    logic [W-1:0] rem_reg, rem_next;

    // Shift and add multiplier.
    logic [MW-1:0] mcand_reg, mcand_next;
    logic [W-1:0]  mplier_reg, mplier_next;
    logic [MW-1:0] acc_reg, acc_next;

    // Step counter shared by the divider and the multiplier.
    logic [CW-1:0] cnt_reg, cnt_next;

    // Output register.
    lcm_res_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;

    uop_t uop;
    logic accept;
    logic in_zero;
    logic jump;
    logic hold;
    logic drain;

    logic [W-1:0] in_a, in_b, in_c;
    logic [W:0]   trial;
    logic [W:0]   diff;

    assign uop = ucode(pc_reg);

    // A new request is taken only while the sequencer is free; a finished
    // result may still wait in the output register meanwhile.
    assign operands_stall = busy_reg;
    assign accept         = operands_valid && !busy_reg;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign in_a = W'(operands.first_value);
    assign in_b = W'(operands.second_value);
    assign in_c = W'(operands.third_value);

    // The third operand counts only when it is used.
    assign in_zero = (in_a == '0) || (in_b == '0) || (operands.use_third && (in_c == '0));

    // One restoring division step: bring down the next dividend bit and try
    // to take the divisor away.
    assign trial = {rem_reg, dn_reg[W-1]};
    assign diff  = trial - {1'b0, dd_reg};

    // The output register is taken when valid and not stalled.
    assign drain = out_valid_reg && !result_stall;

    // The final steps wait while an earlier result still sits unread.
    assign hold = ((uop.op == OP_DONE) || (uop.op == OP_ERR)) && out_valid_reg && result_stall;

    always_comb
    begin
        case (uop.cond)
            C_NONE:  jump = 1'b0;
            C_ERR:   jump = err_reg;
            C_BNZ:   jump = (b_reg != '0);
            C_CNT:   jump = (cnt_reg != '0);
            C_TWO:   jump = two_reg;
            default: jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        two_next       = two_reg;
        err_next       = err_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        dn_next        = dn_reg;
        dd_next        = dd_reg;
        rem_next       = rem_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (drain)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = STEP_LOAD1;
            va_next   = in_a;
            vb_next   = in_b;
            vc_next   = in_c;
            two_next  = !operands.use_third;
            err_next  = in_zero;
        end
        else if (busy_reg)
        begin
            if (!hold)
            begin
                pc_next = jump ? uop.target : pc_reg + PC_W'(1);
            end

            case (uop.op)
                OP_NONE:
                begin
                end
                OP_LOAD1:
                begin
                    a_next = GW'(va_reg);
                    b_next = GW'(vb_reg);
                    k_next = '0;
                end
                OP_LOAD2:
                begin
                    // The two-operand multiple fits in 2W bits.
                    a_next = acc_reg[GW-1:0];
                    b_next = GW'(vc_reg);
                    k_next = '0;
                end
                OP_GCD:
                begin
                    // Binary GCD; does nothing once b has reached zero.
                    if (b_reg != '0)
                    begin
                        if (!a_reg[0] && !b_reg[0])
                        begin
                            a_next = a_reg >> 1;
                            b_next = b_reg >> 1;
                            k_next = k_reg + KW'(1);
                        end
                        else if (!a_reg[0])
                        begin
                            a_next = a_reg >> 1;
                        end
                        else if (!b_reg[0])
                        begin
                            b_next = b_reg >> 1;
                        end
                        else if (a_reg > b_reg)
                        begin
                            a_next = b_reg;
                            b_next = a_reg - b_reg;
                        end
                        else
                        begin
                            b_next = b_reg - a_reg;
                        end
                    end
                end
                OP_GFIX:
                begin
                    // Put back the common factors of two.
                    a_next = a_reg << k_reg;
                end
                OP_DINIT1:
                begin
                    // The gcd divides the first operand, so it fits in W bits.
                    dn_next  = va_reg;
                    dd_next  = a_reg[W-1:0];
                    rem_next = '0;
                    cnt_next = CNT_LAST;
                end
                OP_DINIT2:
                begin
                    dn_next  = vc_reg;
                    dd_next  = a_reg[W-1:0];
                    rem_next = '0;
                    cnt_next = CNT_LAST;
                end
                OP_DSTEP:
                begin
                    if (!diff[W])
                    begin
                        rem_next = diff[W-1:0];
                    end
                    else
                    begin
                        rem_next = trial[W-1:0];
                    end
                    dn_next  = {dn_reg[W-2:0], !diff[W]};
                    cnt_next = cnt_reg - CW'(1);
                end
                OP_MINIT1:
                begin
                    mcand_next  = MW'(dn_reg);
                    mplier_next = vb_reg;
                    acc_next    = '0;
                    cnt_next    = CNT_LAST;
                end
                OP_MINIT2:
                begin
                    mcand_next  = acc_reg;
                    mplier_next = dn_reg;
                    acc_next    = '0;
                    cnt_next    = CNT_LAST;
                end
                OP_MSTEP:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                    cnt_next    = cnt_reg - CW'(1);
                end
                OP_DONE:
                begin
                    if (!hold)
                    begin
                        out_next.multiple = MULT_W'(acc_reg);
                        out_next.status   = STATUS_OK;
                        out_valid_next    = 1'b1;
                        busy_next         = 1'b0;
                    end
                end
                OP_ERR:
                begin
                    if (!hold)
                    begin
                        out_next.multiple = '0;
                        out_next.status   = STATUS_ZERO;
                        out_valid_next    = 1'b1;
                        busy_next         = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= STEP_LOAD1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        vc_reg     <= vc_next;
        two_reg    <= two_next;
        err_reg    <= err_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        dn_reg     <= dn_next;
        dd_reg     <= dd_next;
        rem_reg    <= rem_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    // A taken request starts the sequencer at the first step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && (pc_reg == STEP_LOAD1)))
        else $error("request taken but sequencer not started");

    // An error result always carries a zero multiple.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == STATUS_ZERO)) |-> (out_reg.multiple == '0))
        else $error("error result with nonzero multiple");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (uop.op == OP_DSTEP)) |-> (dd_reg != '0))
        else $error("division by zero in sequencer");

    // The program counter stays inside the control store.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_ERR))
        else $error("program counter outside control store");
`endif

endmodule

`default_nettype wire

[tb/tb_lcm_of_two_or_three.sv]
// Self-checking testbench for the two-or-three operand least common multiple block.
`timescale 1ns / 1ps

module tb_lcm_of_two_or_three
    import lcm_pkg::*;
;

    localparam int OPND_W     = DEF_OPERAND_WIDTH;
    localparam int RANDOM_REQ = 1200;
    // A long receiver hold-off and the longest random gaps on both sides
    // still leave this limit well clear.
    localparam int IDLE_LIMIT = 4000;
    // Trailing wait after the last result.
    localparam int TAIL_CYCLES = 300;

    // A request waiting to be offered. A request marked hold_for_drain is only
    // offered once every earlier result has come back. A request marked
    // back_to_back is followed by the next one with no gap.
    typedef struct {
        lcm_req_t req;
        bit       hold_for_drain;
        bit       back_to_back;
    } lcm_job_t;

    logic     clk            = 1'b0;
    logic     rst_n          = 1'b0;
    lcm_req_t operands       = '0;
    logic     operands_valid = 1'b0;
    logic     operands_stall;
    lcm_res_t result;
    logic     result_valid;
    logic     result_stall   = 1'b0;

    lcm_job_t pending_requests[$];
    lcm_res_t expected_lcms[$];

    int unsigned total_requests  = 0;
    int unsigned requests_taken  = 0;
    int unsigned mismatch_count  = 0;
    int unsigned idle_cycles     = 0;

    // Sender state, touched only by the request driver.
    int unsigned send_gap = 0;
    logic        offering;
    lcm_job_t    job;

    // Receiver state, touched only by the result stall driver.
    int unsigned stall_left   = 0;
    int unsigned steady_left  = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    lcm_res_t want;

    lcm_of_two_or_three #(
        .OPERAND_WIDTH(OPND_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operands      (operands),
        .operands_valid(operands_valid),
        .operands_stall(operands_stall),
        .result        (result),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Least common multiple of two nonzero values, through Euclid's algorithm.
    function automatic logic [63:0] pair_lcm(logic [63:0] x, logic [63:0] y);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] r;
        p = x;
        q = y;
        while (q != 64'd0)
        begin
            r = p % q;
            p = q;
            q = r;
        end
        return (x / p) * y;
    endfunction

    // The result the block owes for one request. A zero among the operands in
    // use gives the error status with a zero multiple; an unused third operand
    // plays no part at all, even when it is zero.
    function automatic lcm_res_t lcm_expected(lcm_req_t req);
        logic [63:0] opnd_mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] m;
        lcm_res_t    res;
        opnd_mask = (64'd1 << OPND_W) - 64'd1;
        a = 64'(req.first_value) & opnd_mask;
        b = 64'(req.second_value) & opnd_mask;
        c = 64'(req.third_value) & opnd_mask;
        if (a == 64'd0 || b == 64'd0 || (req.use_third && c == 64'd0))
        begin
            res.multiple = '0;
            res.status   = STATUS_ZERO;
        end
        else
        begin
            m = pair_lcm(a, b);
            if (req.use_third)
                m = pair_lcm(m, c);
            res.multiple = m[MULT_W-1:0];
            res.status   = STATUS_OK;
        end
        return res;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic add_request(input logic [15:0] first, input logic [15:0] second,
                               input logic [15:0] third, input logic use3,
                               input bit hold, input bit b2b);
        lcm_job_t j;
        j.req.first_value  = first;
        j.req.second_value = second;
        j.req.third_value  = third;
        j.req.use_third    = use3;
        j.hold_for_drain   = hold;
        j.back_to_back     = b2b;
        pending_requests.push_back(j);
        total_requests++;
    endtask

    // Request driver. The prediction is made at the edge where the request is
    // taken, so the store of expected results stays in request order.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            operands_valid <= 1'b0;
        end
        else
        begin
            offering = operands_valid;
            if (operands_valid && !operands_stall)
            begin
                expected_lcms.push_back(lcm_expected(operands));
                requests_taken++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    operands_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].hold_for_drain && expected_lcms.size() != 0))
                begin
                    job = pending_requests.pop_front();
                    operands       <= job.req;
                    operands_valid <= 1'b1;
                    send_gap = job.back_to_back ? 0 : idle_length();
                end
                else
                begin
                    operands_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall driver. Once, part way through, the receiver holds off for a
    // long stretch while the sender keeps offering, so that the block fills up
    // and has to stall its input. Otherwise it stalls at random, with the odd
    // stretch of no stalling at all.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (!holdoff_done && requests_taken >= 400)
            begin
                holdoff_left = 700;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (steady_left > 0)
            begin
                steady_left--;
                result_stall <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 99) == 0)
                    steady_left = $urandom_range(100, 600);
                else
                    stall_left = idle_length();
                result_stall <= 1'b0;
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_lcms.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing outstanding: multiple=%0d status=%0b",
                                          result.multiple, result.status));
            end
            else
            begin
                want = expected_lcms.pop_front();
                if (result.multiple !== want.multiple)
                    report_mismatch($sformatf("multiple: got %0d, expected %0d",
                                              result.multiple, want.multiple));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status: got %0b, expected %0b",
                                              result.status, want.status));
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((operands_valid && !operands_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                         $realtime, idle_cycles, expected_lcms.size());
                $display("FAIL lcm_of_two_or_three");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned shape;
        int unsigned f;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic        use3;

        // Directed requests: smallest and largest operands, each zero case,
        // the ignored third operand, coprime and shared-factor operands.
        add_request(16'd1, 16'd1, 16'd1, 1'b0, 1'b0, 1'b0);
        add_request(16'd1, 16'd1, 16'd1, 1'b1, 1'b0, 1'b0);
        add_request(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_request(16'hFFFF, 16'hFFFE, 16'hFFFD, 1'b1, 1'b0, 1'b1);
        add_request(16'hFFFF, 16'hFFFE, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(16'd0, 16'd5, 16'd7, 1'b1, 1'b0, 1'b0);
        add_request(16'd9, 16'd0, 16'd7, 1'b0, 1'b0, 1'b0);
        add_request(16'd9, 16'd6, 16'd0, 1'b1, 1'b0, 1'b1);
        add_request(16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
        add_request(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
        add_request(16'd12, 16'd18, 16'd0, 1'b0, 1'b0, 1'b0);
        add_request(16'd12, 16'd18, 16'd30, 1'b1, 1'b0, 1'b0);
        add_request(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        add_request(16'h8000, 16'h4000, 16'h0001, 1'b1, 1'b0, 1'b0);
        add_request(16'h8000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_request(16'd65521, 16'd65519, 16'd65497, 1'b1, 1'b0, 1'b0);
        add_request(16'd1, 16'hFFFF, 16'd1, 1'b1, 1'b0, 1'b0);
        add_request(16'd4096, 16'd12288, 16'd49152, 1'b1, 1'b0, 1'b0);
        add_request(16'd7, 16'd7, 16'd7, 1'b1, 1'b0, 1'b0);
        add_request(16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0);
        add_request(16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b1, 1'b0);

        // Random requests. Every few hundred requests a run goes through with
        // no sender gaps, and now and then the sender waits for a full drain.
        for (int i = 0; i < RANDOM_REQ; i++)
        begin
            shape = $urandom_range(0, 99);
            use3  = 1'($urandom_range(0, 1));
            if (shape < 55)
            begin
                a = 16'($urandom_range(0, 65535));
                b = 16'($urandom_range(0, 65535));
                c = 16'($urandom_range(0, 65535));
            end
            else if (shape < 70)
            begin
                a = 16'($urandom_range(1, 48));
                b = 16'($urandom_range(1, 48));
                c = 16'($urandom_range(1, 48));
            end
            else if (shape < 85)
            begin
                // Operands sharing a factor exercise the division by the GCD.
                f = $urandom_range(1, 255);
                a = 16'(f * $urandom_range(1, 255));
                b = 16'(f * $urandom_range(1, 255));
                c = 16'(f * $urandom_range(1, 255));
            end
            else if (shape < 93)
            begin
                a = 16'd1 << $urandom_range(0, 15);
                b = 16'd1 << $urandom_range(0, 15);
                c = 16'($urandom_range(1, 65535));
            end
            else
            begin
                a = 16'($urandom_range(1, 65535));
                b = 16'($urandom_range(1, 65535));
                c = 16'($urandom_range(1, 65535));
                case ($urandom_range(0, 2))
                    0: a = 16'd0;
                    1: b = 16'd0;
                    default: c = 16'd0;
                endcase
            end
            add_request(a, b, c, use3, (i % 250) == 249, (i % 300) < 40);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge so that every update of the rising edge
        // has settled.
        while (requests_taken != total_requests || expected_lcms.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS lcm_of_two_or_three");
        else
            $display("FAIL lcm_of_two_or_three");
        $finish;
    end

endmodule
